>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the sample player.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: %m");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

`endif

>>> src/pps_pkg.sv
// Shared constants, codes and types of the ping-pong sample player.
// No dependencies; every other file of the block but assert_macros.svh imports it.
package pps_pkg;

  localparam int BUF_BYTES  = 512;
  localparam int OFS_W      = $clog2(BUF_BYTES) + 1;
  localparam int ROW_W      = $clog2(BUF_BYTES) - 1;
  localparam int ADDR_W     = ROW_W + 1;
  localparam int BANK_DEPTH = 2 ** ADDR_W;
  localparam int IDX_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int DAC_W      = 12;
  localparam int DAC_SHIFT  = 4;

  localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 16'd32767;
  localparam logic [OFS_W-1:0]    OFS_STEP    = OFS_W'(2);
  localparam logic [OFS_W-1:0]    OFS_END     = OFS_W'(BUF_BYTES);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [ADDR_W-1:0] row;
    logic [BYTE_W-1:0] data;
  } pps_wr_t;

endpackage

>>> src/pps_in_if.sv
// Input channel of the sample player: valid/ready handshake and one input word.
// Depends on pps_pkg.
interface pps_in_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic [0:0]        operation;
  logic [0:0]        load_buffer;
  logic [IDX_W-1:0]  load_index;
  logic [BYTE_W-1:0] load_byte;

  modport source (output valid, operation, load_buffer, load_index, load_byte, input ready);
  modport sink (input valid, operation, load_buffer, load_index, load_byte, output ready);
endinterface

>>> src/pps_out_if.sv
// Output channel of the sample player: valid/ready handshake and one result word.
// Depends on pps_pkg.
interface pps_out_if;
  import pps_pkg::*;

  logic             valid;
  logic             ready;
  logic [DAC_W-1:0] dac_value;
  logic [0:0]       refill_request;
  logic [0:0]       refill_buffer;
  logic [0:0]       finished;

  modport source (output valid, dac_value, refill_request, refill_buffer, finished,
                  input ready);
  modport sink (input valid, dac_value, refill_request, refill_buffer, finished,
                output ready);
endinterface

>>> src/pps_byte_banks.sv
// Sample store split into an even-byte bank and an odd-byte bank, so that one
// read returns both bytes of a sample. Depends on pps_pkg.
module pps_byte_banks (
  input  logic                           clk,
  input  pps_pkg::pps_wr_t               wr,
  input  logic                           rd_en,
  input  logic [pps_pkg::ADDR_W-1:0]     rd_row,
  output logic [pps_pkg::BYTE_W-1:0]     rd_lo,
  output logic [pps_pkg::BYTE_W-1:0]     rd_hi
);
  import pps_pkg::*;

  logic [BYTE_W-1:0] even_mem [BANK_DEPTH];
  logic [BYTE_W-1:0] odd_mem  [BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.bank) begin
      even_mem[wr.row] <= wr.data;
    end
    if (rd_en) begin
      rd_lo <= even_mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.bank) begin
      odd_mem[wr.row] <= wr.data;
    end
    if (rd_en) begin
      rd_hi <= odd_mem[rd_row];
    end
  end

endmodule

>>> src/ping_pong_sample_player.sv
// Top level of the ping-pong sample player: control registers, read pipeline
// and output register. Depends on pps_pkg, pps_in_if, pps_out_if, pps_byte_banks.
//
// Usage: in_ch carries one word per handshake. A load word (operation 0) writes
// load_byte at load_index of buffer load_buffer and produces no result. A tick
// word (operation 1) reads the next 16-bit little-endian sample of the active
// buffer and produces one result word on out_ch with the 12-bit DAC value, a
// refill request naming the buffer just emptied, and the finished flag on the
// last sample. Ticks after the finished sample produce nothing.
// cfg_write_en with cfg_write_data sets the byte count to play; write it only
// while no word is in flight.
// A tick's result is registered in the bank read and s1 registers, then in the
// output register, and from there it is driven on out_ch.
// Throughput: one word per cycle unless out_ch stalls; the two byte banks are read
// in parallel once per tick, and each bank has one write and one read port.
// Reset clears the playback position, the byte count, the stop flag and the
// byte count limit; buffer contents are undefined until loaded and there is no
// clearing pass. When the receiver stalls, the result is held in the output
// register, one more result waits behind it, and then in_ch.ready drops.
`include "assert_macros.svh"

module ping_pong_sample_player (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [pps_pkg::COUNT_W-1:0]   cfg_write_data,
  pps_in_if.sink                        in_ch,
  pps_out_if.source                     out_ch
);
  import pps_pkg::*;

  logic [COUNT_W-1:0] data_size;
  logic               active_buffer;
  logic [OFS_W-1:0]   read_offset;
  logic [COUNT_W-1:0] bytes_played;
  logic               stopped;

  logic s1_valid;
  logic s1_req;
  logic s1_rbuf;
  logic s1_fin;

  logic             out_valid;
  logic [DAC_W-1:0] out_dac;
  logic             out_req;
  logic             out_rbuf;
  logic             out_fin;

  logic               in_ready;
  logic               accept;
  logic               tick_go;
  logic               s1_move;
  logic [OFS_W-1:0]   offset_next;
  logic [COUNT_W:0]   played_sum;
  logic [COUNT_W-1:0] played_next;
  logic               done;
  logic               wrap;
  pps_wr_t            wr;
  logic [BYTE_W-1:0]  rd_lo;
  logic [BYTE_W-1:0]  rd_hi;
  logic [SAMPLE_W-1:0] sample_sum;

  assign s1_move  = s1_valid && (!out_valid || out_ch.ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_ch.valid && in_ready;
  assign tick_go  = accept && (in_ch.operation == OP_TICK) && !stopped;

  assign offset_next = read_offset + OFS_STEP;
  assign played_sum  = {1'b0, bytes_played} + (COUNT_W + 1)'(2);
  assign played_next = played_sum[COUNT_W] ? '1 : played_sum[COUNT_W-1:0];
  assign done        = played_next >= data_size;
  assign wrap        = offset_next >= OFS_END;

  always_comb begin
    wr.en   = accept && (in_ch.operation == OP_LOAD)
              && (OFS_W'(in_ch.load_index) < OFS_END);
    wr.bank = in_ch.load_index[0];
    wr.row  = {in_ch.load_buffer, in_ch.load_index[ROW_W:1]};
    wr.data = in_ch.load_byte;
  end

  pps_byte_banks u_banks (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (tick_go),
    .rd_row ({active_buffer, read_offset[ROW_W:1]}),
    .rd_lo  (rd_lo),
    .rd_hi  (rd_hi)
  );

  assign sample_sum = {rd_hi, rd_lo} + SAMPLE_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_size     <= '0;
      active_buffer <= 1'b0;
      read_offset   <= '0;
      bytes_played  <= '0;
      stopped       <= 1'b0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        data_size <= cfg_write_data;
      end
      if (tick_go) begin
        bytes_played <= played_next;
        if (done) begin
          stopped     <= 1'b1;
          read_offset <= offset_next;
        end else if (wrap) begin
          active_buffer <= !active_buffer;
          read_offset   <= '0;
        end else begin
          read_offset <= offset_next;
        end
      end
      if (tick_go) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1_fin  <= done;
      s1_req  <= !done && wrap;
      s1_rbuf <= !done && wrap && active_buffer;
    end
    if (s1_move) begin
      out_dac  <= sample_sum[SAMPLE_W-1:DAC_SHIFT];
      out_req  <= s1_req;
      out_rbuf <= s1_rbuf;
      out_fin  <= s1_fin;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.dac_value      = out_dac;
  assign out_ch.refill_request = out_req;
  assign out_ch.refill_buffer  = out_rbuf;
  assign out_ch.finished       = out_fin;

  `ASSERT_ALWAYS(a_offset_even, read_offset[0] == 1'b0)
  `ASSERT_NEXT(a_stop_sticky, stopped, stopped)
  `ASSERT_NEXT(a_tick_enters_pipe, tick_go, s1_valid)
  `ASSERT_SAME(a_finish_no_refill, out_valid && out_fin, !out_req)
  `ASSERT_SAME(a_stall_blocks_input, s1_valid && out_valid && !out_ch.ready, !in_ready)

endmodule
